/* hdl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// Moving-average spike detector package
// Shared widths, register indexes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Field widths of the channels and registers.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned MULT_W     = 10;
  localparam int unsigned MINAVG_W   = 12;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default window length.
  localparam int unsigned WINDOW_DEFAULT = 16;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVG    = 2'd1;
  localparam logic [MULT_W-1:0]    SPIKE_MULT_RST = 10'd384;
  localparam logic [MINAVG_W-1:0]  MIN_AVG_RST    = 12'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming sample
    logic update;    // update ring, total, slot and fill count
    logic mult;      // form the alert products and start the divider
    logic div_step;  // one restoring division step
    logic load_out;  // load the result register
  } msd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;  // all quotient bits produced
  } msd_sts_t;

endpackage

/* hdl/msd_in_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one ADC sample per transaction.
// ----------------------------------------------------------------------------
interface msd_in_if
  import msd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/msd_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the average and alert flags per transaction.
// ----------------------------------------------------------------------------
interface msd_out_if
  import msd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [AVG_W-1:0]  average_q4;
  logic              spike_alert;
  logic              warming_up;
  logic [FILL_W-1:0] fill_count;
  logic              sample_taken;

  modport source (output valid, output average_q4, output spike_alert,
                  output warming_up, output fill_count, output sample_taken,
                  input ready);
  modport sink   (input valid, input average_q4, input spike_alert,
                  input warming_up, input fill_count, input sample_taken,
                  output ready);
endinterface

/* hdl/msd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module msd_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/msd_ctrl.sv */
// ----------------------------------------------------------------------------
// Spike detector controller
// Sequences read, update, multiply and divide steps for one sample at a time.
// ----------------------------------------------------------------------------
module msd_ctrl
  import msd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output msd_cmd_t cmd,
  input  msd_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MULT = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register may be reloaded once its transaction has gone.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        state_nxt  = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/msd_dp.sv */
// ----------------------------------------------------------------------------
// Spike detector datapath
// Sample ring, running total, alert products and a restoring divider.
// ----------------------------------------------------------------------------
module msd_dp
  import msd_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  msd_cmd_t              cmd,
  output msd_sts_t              sts,
  output logic [AVG_W-1:0]      average_q4,
  output logic                  spike_alert,
  output logic                  warming_up,
  output logic [FILL_W-1:0]     fill_count,
  output logic                  sample_taken
);

  localparam int unsigned SW   = $clog2(WINDOW);
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned TW   = SAMPLE_W + SW;
  localparam int unsigned DW   = TW + 4;
  localparam int unsigned CNW  = $clog2(DW + 1);
  localparam int unsigned LW   = SAMPLE_W + CW;
  localparam int unsigned RW   = TW + MULT_W;
  localparam int unsigned CMPW = (LW + 8 > RW) ? LW + 8 : RW;
  localparam int unsigned FW   = MINAVG_W + CW;
  localparam logic [SW-1:0]  LastSlot = SW'(WINDOW - 1);
  localparam logic [CW-1:0]  FullK    = CW'(WINDOW);
  localparam logic [CNW-1:0] DivSteps = CNW'(DW);

  // Configuration registers.
  logic [MULT_W-1:0]   mult_r, mult_nxt;
  logic [MINAVG_W-1:0] min_avg_r, min_avg_nxt;

  // Window state.
  logic [TW-1:0] total_r, total_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] filled_r, filled_nxt;

  // Per-item working registers.
  logic [SAMPLE_W-1:0] sample_r;
  logic                taken_r;
  logic [LW-1:0]       lhs_r;
  logic [RW-1:0]       rhs_r;
  logic [FW-1:0]       floor_r;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       quo_r, quo_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;

  // Result register.
  logic [AVG_W-1:0]  avg_out_r;
  logic              alert_out_r;
  logic              warm_out_r;
  logic [FILL_W-1:0] fill_out_r;
  logic              taken_out_r;

  logic [SAMPLE_W-1:0] ring_rdata;
  logic [SAMPLE_W-1:0] old_sample;
  logic                take;
  logic                ring_we;
  logic [CW:0]         rem_sh;
  logic                rem_ge;
  logic                alert;

  // Configuration writes; unknown indexes are dropped.
  always_comb begin
    mult_nxt    = mult_r;
    min_avg_nxt = min_avg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPIKE_MULT: mult_nxt    = MULT_W'(cfg_data);
        CFG_MIN_AVG:    min_avg_nxt = MINAVG_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Sample ring, read at the write slot while idle.
  msd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(slot_r),
    .wdata(sample_r),
    .raddr(slot_r),
    .rdata(ring_rdata)
  );

  // A slot not yet written since reset reads as zero: until the window
  // has filled, the slot being replaced has never been written.
  assign old_sample = (filled_r == FullK) ? ring_rdata : '0;
  assign take       = (sample_r != '0);
  assign ring_we    = cmd.update && take;

  // Window update for a nonzero sample.
  always_comb begin
    total_nxt  = total_r;
    slot_nxt   = slot_r;
    filled_nxt = filled_r;
    if (ring_we) begin
      total_nxt = total_r - TW'(old_sample) + TW'(sample_r);
      slot_nxt  = (slot_r == LastSlot) ? '0 : slot_r + 1'b1;
      if (filled_r != FullK) begin
        filled_nxt = filled_r + 1'b1;
      end
    end
  end

  // Restoring division of total * 16 by the fill count, one bit a step.
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign rem_ge = (rem_sh >= (CW + 1)'(filled_r));

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (cmd.mult) begin
      rem_nxt = '0;
      quo_nxt = {total_r, 4'b0000};
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt = rem_ge ? CW'(rem_sh - (CW + 1)'(filled_r)) : CW'(rem_sh);
      quo_nxt = {quo_r[DW-2:0], rem_ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign sts.div_done = (cnt_r == DivSteps);

  // Alert: sample * 256 * WINDOW above total * multiplier, total above
  // the minimum level times WINDOW, and the window full.
  assign alert = (filled_r == FullK)
              && (CMPW'({lhs_r, 8'b0}) > CMPW'(rhs_r))
              && (FW'(total_r) > floor_r);

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r    <= SPIKE_MULT_RST;
      min_avg_r <= MIN_AVG_RST;
      total_r   <= '0;
      slot_r    <= '0;
      filled_r  <= '0;
      cnt_r     <= '0;
    end else begin
      mult_r    <= mult_nxt;
      min_avg_r <= min_avg_nxt;
      total_r   <= total_nxt;
      slot_r    <= slot_nxt;
      filled_r  <= filled_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.update) begin
      taken_r <= take;
    end
    if (cmd.mult) begin
      lhs_r   <= LW'(sample_r) * LW'(WINDOW);
      rhs_r   <= RW'(total_r) * RW'(mult_r);
      floor_r <= FW'(min_avg_r) * FW'(WINDOW);
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.load_out) begin
      avg_out_r   <= (filled_r == '0) ? '0 : AVG_W'(quo_r);
      alert_out_r <= alert;
      warm_out_r  <= (filled_r != FullK);
      fill_out_r  <= FILL_W'(filled_r);
      taken_out_r <= taken_r;
    end
  end

  assign average_q4   = avg_out_r;
  assign spike_alert  = alert_out_r;
  assign warming_up   = warm_out_r;
  assign fill_count   = fill_out_r;
  assign sample_taken = taken_out_r;

endmodule

/* hdl/moving_average_spike_detector.sv */
// Each sample is worked on alone: the controller updates the window, forms
// the alert products and runs the bit-serial divider for D = 16 + log2(WINDOW)
// steps (D = 20), then loads the result and only then takes the next sample.
// A result not yet taken blocks the next sample once the divider finishes.
// Reset (rst_n, synchronous, active low) empties the window at once and sets
// the multiplier to 1.5 and the minimum average to zero.
// ----------------------------------------------------------------------------
// Moving-average spike detector
// Windowed average of ADC samples in Q.4 with a scaled-average spike alert.
// ----------------------------------------------------------------------------
module moving_average_spike_detector
  import msd_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msd_in_if.sink                in_ch,
  msd_out_if.source             out_ch
);

  msd_cmd_t cmd;
  msd_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Sequencer.
  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic and storage.
  msd_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample   (in_ch.sample),
    .cmd         (cmd),
    .sts         (sts),
    .average_q4  (out_ch.average_q4),
    .spike_alert (out_ch.spike_alert),
    .warming_up  (out_ch.warming_up),
    .fill_count  (out_ch.fill_count),
    .sample_taken(out_ch.sample_taken)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  // The result register is only loaded once the quotient is complete.
  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.div_done)
    else $error("result loaded before division finished");

  // No sample is taken while an earlier one is still being worked on.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("sample accepted while busy");

  // An alert needs a full window.
  a_alert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ch.spike_alert) |-> !out_ch.warming_up)
    else $error("alert raised during warm-up");

  // A zero sample can never raise an alert.
  a_alert_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.sample_taken) |-> !out_ch.spike_alert)
    else $error("alert raised for a zero sample");
`endif

endmodule
